/* hdl/sird_pkg.sv */
// ----------------------------------------------------------------------------
// sird_pkg: shared constants, types and helpers
// Widths, radix limits and character codes for the radix digit converter,
// plus the digit-to-ASCII mapping used on the output side.
// ----------------------------------------------------------------------------
`default_nettype none

package sird_pkg;

	// Width of the signed input that is actually converted (8..64)
	localparam int VALUE_WIDTH = 64;

	// Digit store
	localparam int STORE_DEPTH = 64;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);
	localparam int CNT_W       = ADDR_W + 1;
	localparam int DIGIT_W     = 4;

	// Radix register
	localparam int               RADIX_W     = DIGIT_W + 1;
	localparam logic [RADIX_W-1:0] RADIX_MIN   = RADIX_W'(2);
	localparam logic [RADIX_W-1:0] RADIX_MAX   = RADIX_W'(16);
	localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(10);

	// Divider: magnitude bits consumed per cycle, passes per digit
	localparam int DIV_STEPS  = 8;
	localparam int DIV_CYCLES = (VALUE_WIDTH + DIV_STEPS - 1) / DIV_STEPS;
	localparam int MAG_W      = DIV_CYCLES * DIV_STEPS;
	localparam int CHUNK_W    = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;

	// Character codes
	localparam int                 CHAR_W    = 7;
	localparam logic [CHAR_W-1:0]  CHAR_ZERO = 7'h30;
	localparam logic [CHAR_W-1:0]  CHAR_A    = 7'h61;
	localparam logic [DIGIT_W-1:0] DEC_BASE  = DIGIT_W'(10);

	// Result of one divider pass over a chunk of the magnitude
	typedef struct packed {
		logic [DIGIT_W-1:0]   rem;
		logic [DIV_STEPS-1:0] quot;
	} div_out_t;

	// Map a digit value to its lower-case ASCII character
	function automatic logic [CHAR_W-1:0] digit_ascii(input logic [DIGIT_W-1:0] d);
		logic [CHAR_W-1:0] c;
		if (d < DEC_BASE) begin
			c = CHAR_ZERO + CHAR_W'(d);
		end else begin
			c = CHAR_A + CHAR_W'(d - DEC_BASE);
		end
		return c;
	endfunction

endpackage

`default_nettype wire

/* hdl/signed_integer_to_radix_digits_unit.sv */
// ----------------------------------------------------------------------------
// signed_integer_to_radix_digits_unit: signed integer to radix digit stream
// Converts one signed integer to lower-case ASCII digits of its magnitude,
// most significant first, with a negative flag on every digit.
// ----------------------------------------------------------------------------
// Usage: write the radix (2..16, clamped, reset 10) while idle, then send one
// signed value on s_*. The magnitude is divided by the radix repeatedly in a
// shared slice that consumes 8 magnitude bits per cycle, chunk by chunk for
// each digit; remainders go to a 64-entry digit RAM and are played back in
// reverse, each digit by a RAM read, then a transfer that waits for m_tready.
// s_tready is low for the whole conversion. Zero gives the single digit '0';
// the most negative value converts as 2^63. tlast marks the final digit.
// ----------------------------------------------------------------------------
`default_nettype none

module signed_integer_to_radix_digits_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Configuration: radix write
	input  wire logic        cfg_we,
	input  wire logic [4:0]  cfg_wdata,   // radix
	// Input stream
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [63:0] s_tdata,     // [63:0] value
	// Output stream
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [7:0]       m_tdata,     // [6:0] digit_char, [7] zero fill
	output logic             m_tuser,     // [0] negative
	output logic             m_tlast
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_READ = 2'd2;
	localparam logic [1:0] ST_SHOW = 2'd3;

	logic [1:0]                          state_q;
	logic [sird_pkg::RADIX_W-1:0]        radix_q;
	logic [sird_pkg::MAG_W-1:0]          mag_q;
	logic [sird_pkg::DIGIT_W-1:0]        rem_q;
	logic                                neg_q;
	logic [sird_pkg::CHUNK_W-1:0]        chunk_q;
	logic [sird_pkg::CNT_W-1:0]          cnt_q;
	logic [sird_pkg::ADDR_W-1:0]         rd_idx_q;

	logic [sird_pkg::VALUE_WIDTH-1:0]    in_val;
	logic                                in_neg;
	logic [sird_pkg::VALUE_WIDTH-1:0]    in_mag;
	sird_pkg::div_out_t                  div_res;
	logic [sird_pkg::MAG_W-1:0]          quot_next;
	logic [sird_pkg::CNT_W-1:0]          cnt_next;
	logic                                last_chunk;
	logic                                div_done;
	logic                                s_xfer;
	logic                                m_xfer;
	logic                                ram_we;
	logic                                ram_re;
	logic [sird_pkg::DIGIT_W-1:0]        ram_rdata;

	// Take the signed input apart into sign and magnitude
	assign in_val = s_tdata[sird_pkg::VALUE_WIDTH-1:0];
	assign in_neg = in_val[sird_pkg::VALUE_WIDTH-1];
	assign in_mag = in_neg ? (~in_val + 1'b1) : in_val;

	assign s_tready = (state_q == ST_IDLE);
	assign s_xfer   = s_tvalid && s_tready;
	assign m_xfer   = m_tvalid && m_tready;

	// Shared division slice on the top chunk of the magnitude
	sird_div_unit u_div (
		.rem_in  (rem_q),
		.bits_in (mag_q[sird_pkg::MAG_W-1 -: sird_pkg::DIV_STEPS]),
		.radix   (radix_q),
		.res     (div_res)
	);

	assign quot_next  = (mag_q << sird_pkg::DIV_STEPS) | sird_pkg::MAG_W'(div_res.quot);
	assign cnt_next   = cnt_q + 1'b1;
	assign last_chunk = (chunk_q == sird_pkg::CHUNK_W'(sird_pkg::DIV_CYCLES - 1));
	assign div_done   = last_chunk &&
	                    ((quot_next == '0) || (cnt_next == sird_pkg::CNT_W'(sird_pkg::STORE_DEPTH)));

	assign ram_we = (state_q == ST_DIV) && last_chunk;
	assign ram_re = (state_q == ST_READ);

	// Digit store
	sird_ram #(
		.WIDTH (sird_pkg::DIGIT_W),
		.DEPTH (sird_pkg::STORE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (cnt_q[sird_pkg::ADDR_W-1:0]),
		.wdata (div_res.rem),
		.re    (ram_re),
		.raddr (rd_idx_q),
		.rdata (ram_rdata)
	);

	// Radix register, clamp writes to the legal range
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q <= sird_pkg::RADIX_RESET;
		end else if (cfg_we) begin
			priority if (cfg_wdata < sird_pkg::RADIX_MIN) begin
				radix_q <= sird_pkg::RADIX_MIN;
			end else if (cfg_wdata > sird_pkg::RADIX_MAX) begin
				radix_q <= sird_pkg::RADIX_MAX;
			end else begin
				radix_q <= cfg_wdata;
			end
		end
	end

	// Sequencer: accept, divide digit by digit, play back in reverse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			chunk_q  <= '0;
			cnt_q    <= '0;
			rd_idx_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (s_xfer) begin
						state_q <= ST_DIV;
						chunk_q <= '0;
						cnt_q   <= '0;
					end
				end
				ST_DIV: begin
					if (last_chunk) begin
						chunk_q <= '0;
						cnt_q   <= cnt_next;
						if (div_done) begin
							rd_idx_q <= cnt_q[sird_pkg::ADDR_W-1:0];
							state_q  <= ST_READ;
						end
					end else begin
						chunk_q <= chunk_q + 1'b1;
					end
				end
				ST_READ: begin
					state_q <= ST_SHOW;
				end
				ST_SHOW: begin
					if (m_xfer) begin
						if (rd_idx_q == '0) begin
							state_q <= ST_IDLE;
						end else begin
							rd_idx_q <= rd_idx_q - 1'b1;
							state_q  <= ST_READ;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Magnitude, remainder and sign; clear the remainder between digits
	always_ff @(posedge clk) begin
		if (s_xfer) begin
			mag_q <= sird_pkg::MAG_W'(in_mag);
			rem_q <= '0;
			neg_q <= in_neg;
		end else if (state_q == ST_DIV) begin
			mag_q <= quot_next;
			rem_q <= last_chunk ? '0 : div_res.rem;
		end
	end

	// Output side, driven from the registered RAM read
	assign m_tvalid = (state_q == ST_SHOW);
	assign m_tdata  = {1'b0, sird_pkg::digit_ascii(ram_rdata)};
	assign m_tuser  = neg_q;
	assign m_tlast  = (rd_idx_q == '0);

	// Radix never leaves its legal range
	a_radix_range: assert property (@(posedge clk) disable iff (!arst_n)
		(radix_q >= sird_pkg::RADIX_MIN) && (radix_q <= sird_pkg::RADIX_MAX))
		else $error("radix register out of range");

	// Every stored digit is below the radix
	a_digit_below_radix: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (div_res.rem < radix_q))
		else $error("stored digit not below radix");

	// An accepted item starts a fresh division pass
	a_accept_starts_div: assert property (@(posedge clk) disable iff (!arst_n)
		s_xfer |=> (state_q == ST_DIV) && (cnt_q == '0) && (chunk_q == '0))
		else $error("accept did not start division");

	// The final digit transfer frees the input side
	a_last_frees_input: assert property (@(posedge clk) disable iff (!arst_n)
		(m_xfer && m_tlast) |=> s_tready)
		else $error("input not ready after last digit");

	// Never ready for input while a digit is offered
	a_sides_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid))
		else $error("input ready while output valid");

	// Digit count never exceeds the store depth
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= sird_pkg::CNT_W'(sird_pkg::STORE_DEPTH))
		else $error("digit count beyond store depth");

endmodule

`default_nettype wire

/* hdl/sird_ram.sv */
// ----------------------------------------------------------------------------
// sird_ram: generic single-port-write, single-port-read RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module sird_ram #(
	parameter int WIDTH = 4,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port, hold data when not reading
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

/* hdl/sird_div_unit.sv */
// ----------------------------------------------------------------------------
// sird_div_unit: shared radix division slice
// Runs DIV_STEPS restoring-division steps against the radix, taking the
// running remainder and the next magnitude bits (most significant first)
// and giving the quotient bits and the new remainder.
// ----------------------------------------------------------------------------
`default_nettype none

module sird_div_unit (
	input  wire logic [sird_pkg::DIGIT_W-1:0]   rem_in,
	input  wire logic [sird_pkg::DIV_STEPS-1:0] bits_in,
	input  wire logic [sird_pkg::RADIX_W-1:0]   radix,
	output sird_pkg::div_out_t                  res
);

	// Shift in one bit, compare and subtract, per step
	always_comb begin
		logic [sird_pkg::RADIX_W-1:0]   t;
		logic [sird_pkg::DIGIT_W-1:0]   r;
		logic [sird_pkg::DIV_STEPS-1:0] q;
		r = rem_in;
		q = '0;
		for (int i = sird_pkg::DIV_STEPS - 1; i >= 0; i--) begin
			t = {r, bits_in[i]};
			if (t >= radix) begin
				t    = t - radix;
				q[i] = 1'b1;
			end
			r = t[sird_pkg::DIGIT_W-1:0];
		end
		res.rem  = r;
		res.quot = q;
	end

endmodule

`default_nettype wire
